// File: rtl/bat_pkg.sv
// Package: shared types, codes and constants of the block-average tone quantizer.
package bat_pkg;

  localparam int MAX_WIDTH_DEF    = 4096;
  localparam int MAX_BLOCK_DEF    = 64;
  localparam int TONE_ENTRIES_DEF = 256;
  localparam int HEIGHT_LIMIT     = 4096;
  localparam int FIFO_DEPTH       = 4;

  // Configuration register indexes
  localparam logic [1:0] REG_BLOCK_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;
  localparam logic [1:0] REG_COLOR_MODE   = 2'd3;

  // Input opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TABLE = 1'b1;

  typedef enum logic {
    KIND_TILE  = 1'b0,
    KIND_TABLE = 1'b1
  } bat_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SEND
  } bat_state_e;

  // Queue status seen by the front end and the back end
  typedef struct packed {
    logic       empty;
    logic [2:0] count;
  } bat_fifo_stat_t;

endpackage

// File: rtl/bat_fifo.sv
// Short job queue between the front end and the back end.
module bat_fifo #(
  parameter int DATA_W = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [DATA_W-1:0]       push_data_i,
  input  logic                    pop_i,
  output logic [DATA_W-1:0]       pop_data_o,
  output bat_pkg::bat_fifo_stat_t stat_o
);
  import bat_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  logic [DATA_W-1:0] mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]        count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + {2'b0, push_i} - {2'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == 3'd0);
  assign stat_o.count = count_q;

endmodule

// File: rtl/bat_front.sv
// Front end: configuration, luminance, tile counters and the column-sum line store.
module bat_front #(
  parameter int MAX_WIDTH = bat_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BLOCK = bat_pkg::MAX_BLOCK_DEF,
  parameter int JOB_W     = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [12:0]             cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    opcode_i,
  input  logic [7:0]              red_i,
  input  logic [7:0]              green_i,
  input  logic [7:0]              blue_i,
  input  logic [7:0]              table_index_i,
  input  logic [7:0]              table_value_i,
  input  bat_pkg::bat_fifo_stat_t fifo_stat_i,
  output logic                    push_o,
  output logic [JOB_W-1:0]        push_data_o
);
  import bat_pkg::*;

  localparam int PC_W  = $clog2(MAX_WIDTH);
  localparam int BW_W  = $clog2(MAX_BLOCK + 1);
  localparam int RS_W  = 16 + BW_W;
  localparam int CS_W  = RS_W + BW_W + 1;
  localparam int CNT_W = 2 * BW_W + 1;
  localparam int HR_W  = $clog2(HEIGHT_LIMIT);

  // configuration registers
  logic [6:0]  block_width_q;
  logic [12:0] image_width_q, image_height_q;
  logic        color_mode_q;
  logic        restart;

  assign cfg_ready_o = 1'b1;
  assign restart     = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_width_q  <= 7'd1;
      image_width_q  <= 13'd1;
      image_height_q <= 13'd1;
      color_mode_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BLOCK_WIDTH:  block_width_q  <= cfg_data_i[6:0];
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
        REG_COLOR_MODE:   color_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [BW_W-1:0] bw_c;
  logic [PC_W:0]   w_c;
  logic [12:0]     h_c;

  always_comb begin
    if (block_width_q == 7'd0) bw_c = BW_W'(1);
    else if (32'(block_width_q) > MAX_BLOCK) bw_c = BW_W'(MAX_BLOCK);
    else bw_c = BW_W'(block_width_q);
    if (image_width_q == 13'd0) w_c = (PC_W+1)'(1);
    else if (32'(image_width_q) > MAX_WIDTH) w_c = (PC_W+1)'(MAX_WIDTH);
    else w_c = (PC_W+1)'(image_width_q);
    if (image_height_q == 13'd0) h_c = 13'd1;
    else if (32'(image_height_q) > HEIGHT_LIMIT) h_c = 13'(HEIGHT_LIMIT);
    else h_c = image_height_q;
  end

  // position counters
  logic [PC_W-1:0] pixel_column_q, tile_column_q;
  logic [HR_W-1:0] pixel_row_q;
  logic [BW_W:0]   row_in_strip_q;
  logic [BW_W-1:0] col_in_tile_q;
  logic [RS_W-1:0] running_sum_q;

  logic            accept, pix_acc, tbl_acc;
  logic [15:0]     lum;
  logic [RS_W-1:0] rs_sum;
  logic            img_row_end, img_last_row, img_end, col_last, row_last;
  logic [CNT_W-1:0] count;

  assign in_stall_o = (fifo_stat_i.count >= 3'(FIFO_DEPTH - 1));
  assign accept     = in_valid_i && !in_stall_o;
  assign pix_acc    = accept && (opcode_i == OP_PIXEL);
  assign tbl_acc    = accept && (opcode_i == OP_TABLE);

  always_comb begin
    if (color_mode_q)
      lum = 16'(red_i) * 16'd77 + 16'(green_i) * 16'd150 + 16'(blue_i) * 16'd29;
    else
      lum = {red_i, 8'd0};
    rs_sum       = running_sum_q + RS_W'(lum);
    img_row_end  = ({1'b0, pixel_column_q} >= w_c - 1'b1);
    img_last_row = (13'(pixel_row_q) >= h_c - 13'd1);
    img_end      = img_row_end && img_last_row;
    col_last     = (col_in_tile_q >= bw_c - 1'b1) || img_row_end;
    row_last     = (row_in_strip_q >= {bw_c, 1'b0} - 1'b1) || img_last_row;
    count        = (CNT_W'(col_in_tile_q) + 1'b1) * (CNT_W'(row_in_strip_q) + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_column_q <= '0;
      tile_column_q  <= '0;
      pixel_row_q    <= '0;
      row_in_strip_q <= '0;
      col_in_tile_q  <= '0;
      running_sum_q  <= '0;
    end else if (restart) begin
      pixel_column_q <= '0;
      tile_column_q  <= '0;
      pixel_row_q    <= '0;
      row_in_strip_q <= '0;
      col_in_tile_q  <= '0;
      running_sum_q  <= '0;
    end else if (pix_acc) begin
      running_sum_q <= col_last ? '0 : rs_sum;
      if (img_row_end) begin
        pixel_column_q <= '0;
        col_in_tile_q  <= '0;
        tile_column_q  <= '0;
        if (img_last_row) begin
          pixel_row_q    <= '0;
          row_in_strip_q <= '0;
        end else begin
          pixel_row_q    <= pixel_row_q + 1'b1;
          row_in_strip_q <= row_last ? '0 : row_in_strip_q + 1'b1;
        end
      end else begin
        pixel_column_q <= pixel_column_q + 1'b1;
        if (col_last) begin
          col_in_tile_q <= '0;
          tile_column_q <= tile_column_q + 1'b1;
        end else begin
          col_in_tile_q <= col_in_tile_q + 1'b1;
        end
      end
    end
  end

  // update stage: column-sum read-modify-write and job push
  logic             b_vld_q, b_tile_q;
  logic [RS_W-1:0]  b_sum_q;
  logic [PC_W-1:0]  b_addr_q;
  logic             b_last_q, b_first_q, b_rend_q, b_iend_q;
  logic [CNT_W-1:0] b_cnt_q;
  logic [7:0]       b_tidx_q, b_tval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= (pix_acc && col_last) || tbl_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    b_tile_q  <= pix_acc;
    b_sum_q   <= rs_sum;
    b_addr_q  <= tile_column_q;
    b_last_q  <= row_last;
    b_first_q <= (row_in_strip_q == '0);
    b_rend_q  <= img_row_end;
    b_iend_q  <= img_end;
    b_cnt_q   <= count;
    b_tidx_q  <= table_index_i;
    b_tval_q  <= table_value_i;
  end

  logic [CS_W-1:0] col_mem [MAX_WIDTH];
  logic [CS_W-1:0] rd_q, old_sum, new_sum, wr_data;
  logic            rd_en, wr_en;
  logic            fwd_vld_q;
  logic [PC_W-1:0] fwd_addr_q;
  logic [CS_W-1:0] fwd_data_q;

  assign rd_en   = pix_acc && col_last;
  assign wr_en   = b_vld_q && b_tile_q;
  // the first row of a strip starts each column sum from zero
  assign old_sum = b_first_q ? '0 :
                   (fwd_vld_q && fwd_addr_q == b_addr_q) ? fwd_data_q : rd_q;
  assign new_sum = old_sum + CS_W'(b_sum_q);
  assign wr_data = b_last_q ? '0 : new_sum;

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= col_mem[tile_column_q];
    if (wr_en) col_mem[b_addr_q] <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= b_addr_q;
    fwd_data_q <= wr_data;
  end

  bat_kind_e kind;
  assign kind        = b_tile_q ? KIND_TILE : KIND_TABLE;
  assign push_o      = b_vld_q && (!b_tile_q || b_last_q);
  assign push_data_o = {kind, new_sum, b_cnt_q, b_rend_q, b_iend_q, b_tidx_q, b_tval_q};

endmodule

// File: rtl/bat_back.sv
// Back end: tile average divider, tone table and result register.
module bat_back #(
  parameter int MAX_BLOCK    = bat_pkg::MAX_BLOCK_DEF,
  parameter int TONE_ENTRIES = bat_pkg::TONE_ENTRIES_DEF,
  parameter int JOB_W        = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bat_pkg::bat_fifo_stat_t fifo_stat_i,
  input  logic [JOB_W-1:0]        job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              char_code_o,
  output logic                    row_end_o,
  output logic                    image_end_o
);
  import bat_pkg::*;

  localparam int BW_W  = $clog2(MAX_BLOCK + 1);
  localparam int CS_W  = 2 * BW_W + 17;
  localparam int CNT_W = 2 * BW_W + 1;
  localparam int DW    = CNT_W + 17;

  bat_kind_e        j_kind;
  logic             j_kind_bit;
  logic [CS_W-1:0]  j_sum;
  logic [CNT_W-1:0] j_cnt;
  logic             j_rend, j_iend;
  logic [7:0]       j_tidx, j_tval;

  assign {j_kind_bit, j_sum, j_cnt, j_rend, j_iend, j_tidx, j_tval} = job_i;
  assign j_kind = bat_kind_e'(j_kind_bit);

  bat_state_e state_q, state_d;
  logic [DW-1:0] rem_q, rem_d, div_q, div_d;
  logic [8:0]    quo_q, quo_d;
  logic [3:0]    step_q, step_d;
  logic          rend_q, iend_q, load_job;
  logic          tbl_we, tbl_re, out_load;
  logic [7:0]    avg;
  logic          out_vld_q;

  assign avg = quo_q[8] ? 8'hFF : quo_q[7:0];

  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    div_d    = div_q;
    quo_d    = quo_q;
    step_d   = step_q;
    pop_o    = 1'b0;
    tbl_we   = 1'b0;
    tbl_re   = 1'b0;
    out_load = 1'b0;
    load_job = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!fifo_stat_i.empty) begin
          pop_o = 1'b1;
          if (j_kind == KIND_TABLE) begin
            tbl_we = 1'b1;
          end else begin
            load_job = 1'b1;
            // rounding: (sum + count*128) / (count*256), quotient bit 8 first
            rem_d    = DW'(j_sum) + DW'({j_cnt, 7'd0});
            div_d    = {1'b0, j_cnt, 16'd0};
            quo_d    = '0;
            step_d   = '0;
            state_d  = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (rem_q >= div_q) begin
          rem_d = rem_q - div_q;
          quo_d = {quo_q[7:0], 1'b1};
        end else begin
          quo_d = {quo_q[7:0], 1'b0};
        end
        div_d  = div_q >> 1;
        step_d = step_q + 1'b1;
        if (step_q == 4'd8) state_d = ST_READ;
      end
      ST_READ: begin
        tbl_re  = 1'b1;
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    if (load_job) begin
      rend_q <= j_rend;
      iend_q <= j_iend;
    end
  end

  logic [7:0] tone_mem [TONE_ENTRIES];
  logic [7:0] tone_q;

  always_ff @(posedge clk_i) begin
    if (tbl_we) tone_mem[j_tidx] <= j_tval;
    if (tbl_re) tone_q <= tone_mem[avg];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      char_code_o <= tone_q;
      row_end_o   <= rend_q;
      image_end_o <= iend_q;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

// File: rtl/block_average_tone_quantizer.sv
// Top level of the block-average tone quantizer.
// Pixels (opcode pixel) stream in raster order and tone table writes (opcode table)
// share the same input channel. The front end takes one item per cycle while the job
// queue has room; it forms 8.8 luminance, sums tiles of block_width by 2*block_width
// pixels through a per-column line store (read-modify-write, registered after the
// accept, with a bypass for back-to-back hits on the same column), and queues one job
// per finished tile or table write. A table job goes into the tone table; a tile job
// runs the queue pop, 9 steps of the restoring divider, the registered tone table
// read and the result register load before the back end pops the next job. When
// tiles come faster than the back end takes them, the divider sets the pace and the
// input stalls. Any configuration write restarts the image; the column store needs no
// clearing pass because the first row of each strip overwrites its entries. Tone
// table entries must be written before a tile can select them.
module block_average_tone_quantizer #(
  parameter int MAX_WIDTH    = bat_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BLOCK    = bat_pkg::MAX_BLOCK_DEF,
  parameter int TONE_ENTRIES = bat_pkg::TONE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  table_index_i,
  input  logic [7:0]  table_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  char_code_o,
  output logic        row_end_o,
  output logic        image_end_o
);
  import bat_pkg::*;

  localparam int BW_W  = $clog2(MAX_BLOCK + 1);
  // job: kind, column sum, pixel count, row end, image end, table index, table value
  localparam int JOB_W = 1 + (2 * BW_W + 17) + (2 * BW_W + 1) + 2 + 16;

  logic             push, pop;
  logic [JOB_W-1:0] push_data, pop_data;
  bat_fifo_stat_t   fifo_stat;

  // front end: classify items, keep tile sums, hand off finished tiles and table writes
  bat_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK),
    .JOB_W     (JOB_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .fifo_stat_i   (fifo_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  // decouple the two halves so each side can stall on its own
  bat_fifo #(
    .DATA_W (JOB_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  // back end: write the tone table, divide, look up the character, hold the result transaction
  bat_back #(
    .MAX_BLOCK    (MAX_BLOCK),
    .TONE_ENTRIES (TONE_ENTRIES),
    .JOB_W        (JOB_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .job_i       (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .row_end_o   (row_end_o),
    .image_end_o (image_end_o)
  );

endmodule
